### rtl/dla_pkg.sv
// dla_pkg: types, constants and defaults shared by the lease allocator files
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dla_pkg;

    localparam int DEF_LEASE_ENTRIES = 64;
    localparam int DEF_POOL_FIRST    = 10;
    localparam int DEF_POOL_END      = 100;

    localparam logic [31:0] BCAST_IP   = 32'hFFFF_FFFF;
    localparam logic [15:0] BCAST_PORT = 16'd68;

    localparam logic MODE_DISCOVER = 1'b0;
    localparam logic MODE_REQUEST  = 1'b1;
    localparam logic REPLY_OFFER   = 1'b0;
    localparam logic REPLY_ACK     = 1'b1;

    // queue between front and back, depth a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef struct packed {
        logic        mode;
        logic [47:0] client_mac;
        logic [31:0] requested_ip;
        logic [31:0] source_ip;
        logic [15:0] source_port;
    } in_item_t;

    typedef struct packed {
        logic        reply_kind;
        logic [31:0] reply_ip;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic        table_full;
    } out_item_t;

    typedef struct packed {
        logic        mode;
        logic [47:0] mac;
        logic [31:0] req_ip;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
    } job_t;

    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] addr;
    } lease_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EMIT
    } back_state_t;

endpackage

`default_nettype wire

### rtl/dla_ram.sv
// dla_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/dla_front.sv
// dla_front: input register stage, works out the reply destination of each item
// depends on dla_pkg
`timescale 1ns / 1ps
`default_nettype none

module dla_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire dla_pkg::in_item_t req_item,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output dla_pkg::job_t          push_job
);

    logic          valid_reg;
    logic          valid_next;
    dla_pkg::job_t job_reg;
    dla_pkg::job_t job_next;
    logic          accept;

    assign req_stall  = valid_reg && !push_ready;
    assign accept     = req_valid && !req_stall;
    assign push_valid = valid_reg;
    assign push_job   = job_reg;

    always_comb
    begin
        job_next.mode   = req_item.mode;
        job_next.mac    = req_item.client_mac;
        job_next.req_ip = req_item.requested_ip;
        if (req_item.source_ip == 32'd0)
        begin
            job_next.dest_ip   = dla_pkg::BCAST_IP;
            job_next.dest_port = dla_pkg::BCAST_PORT;
        end
        else
        begin
            job_next.dest_ip   = req_item.source_ip;
            job_next.dest_port = req_item.source_port;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

endmodule

`default_nettype wire

### rtl/dla_queue.sv
// dla_queue: short fifo of classified items between front and back
// depends on dla_pkg
`timescale 1ns / 1ps
`default_nettype none

module dla_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire dla_pkg::job_t push_job,
    output logic               pop_valid,
    input  wire logic          pop_take,
    output dla_pkg::job_t      pop_job
);

    localparam int CW = $clog2(dla_pkg::QUEUE_DEPTH + 1);

    dla_pkg::job_t               slot_reg [dla_pkg::QUEUE_DEPTH];
    logic [dla_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [dla_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [dla_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [dla_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = count_reg != CW'(dla_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_take && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### rtl/dla_back.sv
// dla_back: lease table sequencer, serial search, pool allocation and reply register
// depends on dla_pkg and dla_ram
`timescale 1ns / 1ps
`default_nettype none

module dla_back #(
    parameter int LEASE_ENTRIES = dla_pkg::DEF_LEASE_ENTRIES,
    parameter int POOL_FIRST    = dla_pkg::DEF_POOL_FIRST,
    parameter int POOL_END      = dla_pkg::DEF_POOL_END
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [31:0]   network_base,
    input  wire logic          pop_valid,
    output logic               pop_take,
    input  wire dla_pkg::job_t pop_job,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output dla_pkg::out_item_t rsp_item
);

    localparam int IDX_W     = (LEASE_ENTRIES > 1) ? $clog2(LEASE_ENTRIES) : 1;
    localparam int CNT_W     = $clog2(LEASE_ENTRIES + 1);
    localparam int POOL_SIZE = (POOL_END > POOL_FIRST) ? (POOL_END - POOL_FIRST) : 0;
    localparam int POOL_W    = (POOL_SIZE > 0) ? $clog2(POOL_SIZE + 1) : 1;

    dla_pkg::back_state_t state_reg;
    dla_pkg::back_state_t state_next;
    dla_pkg::job_t        job_reg;
    logic [CNT_W-1:0]     issue_reg;
    logic [CNT_W-1:0]     issue_next;
    logic                 cmp_vld_reg;
    logic                 cmp_vld_next;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;
    logic [POOL_W-1:0]    pool_reg;
    logic [POOL_W-1:0]    pool_next;
    dla_pkg::out_item_t   res_reg;
    dla_pkg::out_item_t   res_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    dla_pkg::out_item_t   out_reg;

    logic                 rd_en;
    dla_pkg::lease_t      rdata;
    logic                 hit;
    logic                 miss;
    logic                 room;
    logic                 emit;
    logic                 out_load;
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    dla_pkg::lease_t      wdata;
    logic [31:0]          pool_addr;

    dla_ram #(
        .WIDTH ($bits(dla_pkg::lease_t)),
        .DEPTH (LEASE_ENTRIES),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    assign rd_en     = (state_reg == dla_pkg::BK_SCAN) && (issue_reg < fill_reg);
    assign hit       = (state_reg == dla_pkg::BK_SCAN) && cmp_vld_reg
                       && (rdata.mac == job_reg.mac);
    assign miss      = (state_reg == dla_pkg::BK_SCAN) && !cmp_vld_reg && !rd_en;
    assign room      = fill_reg < CNT_W'(LEASE_ENTRIES);
    assign pool_addr = network_base + 32'(POOL_FIRST - 1) + 32'(pool_reg);
    assign out_load  = (state_reg == dla_pkg::BK_EMIT) && (!out_valid_reg || !rsp_stall);
    assign pop_take  = (state_reg == dla_pkg::BK_IDLE) && pop_valid;
    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dla_pkg::BK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = dla_pkg::BK_SCAN;
                end
            end
            dla_pkg::BK_SCAN:
            begin
                if (hit || miss)
                begin
                    state_next = emit ? dla_pkg::BK_EMIT : dla_pkg::BK_IDLE;
                end
            end
            dla_pkg::BK_EMIT:
            begin
                if (out_load)
                begin
                    state_next = dla_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = dla_pkg::BK_IDLE;
            end
        endcase
    end

    // lease decision and table update
    always_comb
    begin
        emit      = 1'b0;
        we        = 1'b0;
        waddr     = fill_reg[IDX_W-1:0];
        wdata.mac = job_reg.mac;
        wdata.addr = job_reg.req_ip;
        fill_next = fill_reg;
        pool_next = pool_reg;

        res_next.reply_kind = job_reg.mode;
        res_next.reply_ip   = job_reg.req_ip;
        res_next.dest_ip    = job_reg.dest_ip;
        res_next.dest_port  = job_reg.dest_port;
        res_next.table_full = 1'b0;

        if (job_reg.mode == dla_pkg::MODE_DISCOVER)
        begin
            res_next.reply_kind = dla_pkg::REPLY_OFFER;
            if (hit)
            begin
                emit              = 1'b1;
                res_next.reply_ip = rdata.addr;
            end
            else if (miss && room && (pool_reg != '0))
            begin
                emit              = 1'b1;
                res_next.reply_ip = pool_addr;
                we                = 1'b1;
                wdata.addr        = pool_addr;
                fill_next         = fill_reg + 1'b1;
                pool_next         = pool_reg - 1'b1;
            end
        end
        else
        begin
            res_next.reply_kind = dla_pkg::REPLY_ACK;
            if (hit)
            begin
                emit  = 1'b1;
                we    = 1'b1;
                waddr = cmp_idx_reg;
            end
            else if (miss)
            begin
                emit = 1'b1;
                if (room)
                begin
                    we        = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    res_next.table_full = 1'b1;
                end
            end
        end
    end

    // scan pointers and reply register
    always_comb
    begin
        issue_next   = issue_reg;
        cmp_vld_next = 1'b0;
        if (state_reg == dla_pkg::BK_IDLE)
        begin
            issue_next = '0;
        end
        else if (rd_en)
        begin
            issue_next   = issue_reg + 1'b1;
            cmp_vld_next = 1'b1;
        end
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dla_pkg::BK_IDLE;
            issue_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            fill_reg      <= '0;
            pool_reg      <= POOL_W'(POOL_SIZE);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            cmp_vld_reg   <= cmp_vld_next;
            fill_reg      <= fill_next;
            pool_reg      <= pool_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_take)
        begin
            job_reg <= pop_job;
        end
        cmp_idx_reg <= issue_reg[IDX_W-1:0];
        if (hit || miss)
        begin
            res_reg <= res_next;
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

`default_nettype wire

### rtl/dhcp_lease_allocator_top.sv
// dhcp_lease_allocator_top: top level, network base register and the three stages
// depends on dla_pkg, dla_front, dla_queue, dla_back
`timescale 1ns / 1ps
`default_nettype none

// Lease table of a small DHCP server. Each discover or request item is held in
// a front register, passed through a two-deep queue and handled by a back
// sequencer that searches the occupied lease entries one per cycle through the
// read port of the lease memory. A new item is taken while an earlier one is
// still being searched or while a reply waits to be taken. Leases fill the
// table from entry 0 upwards and are never removed, so occupancy is a fill
// count and no clearing pass follows reset.
// Write network_base only while the block is idle.

module dhcp_lease_allocator_top #(
    parameter int LEASE_ENTRIES = dla_pkg::DEF_LEASE_ENTRIES,
    parameter int POOL_FIRST    = dla_pkg::DEF_POOL_FIRST,
    parameter int POOL_END      = dla_pkg::DEF_POOL_END
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire dla_pkg::in_item_t  req_item,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output dla_pkg::out_item_t      rsp_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [31:0]        cfg_data
);

    logic [31:0]   base_reg;
    logic          push_valid;
    logic          push_ready;
    dla_pkg::job_t push_job;
    logic          pop_valid;
    logic          pop_take;
    dla_pkg::job_t pop_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            base_reg <= cfg_data;
        end
    end

    dla_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_item   (req_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    dla_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_take   (pop_take),
        .pop_job    (pop_job)
    );

    dla_back #(
        .LEASE_ENTRIES (LEASE_ENTRIES),
        .POOL_FIRST    (POOL_FIRST),
        .POOL_END      (POOL_END)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .network_base (base_reg),
        .pop_valid    (pop_valid),
        .pop_take     (pop_take),
        .pop_job      (pop_job),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp_item     (rsp_item)
    );

endmodule

`default_nettype wire

### test/dla_lease_checker.sv
`timescale 1ns / 1ps
// dla_lease_checker: watches the request, reply and base register channels of the
// lease allocator, predicts each reply and compares it field by field
// depends on dla_pkg
module dla_lease_checker
    import dla_pkg::*;
#(
    parameter int LEASE_ENTRIES = DEF_LEASE_ENTRIES,
    parameter int POOL_FIRST    = DEF_POOL_FIRST,
    parameter int POOL_END      = DEF_POOL_END
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  in_item_t    req_item,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  out_item_t   rsp_item,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          mismatch_count,
    output int          outstanding
);

    logic [31:0] net_base;
    bit          lease_used [LEASE_ENTRIES];
    logic [47:0] lease_mac_tab [LEASE_ENTRIES];
    logic [31:0] lease_ip_tab [LEASE_ENTRIES];
    int          pool_left;
    out_item_t   expected_replies [$];

    task automatic report(input string what, input logic [63:0] exp_v,
                          input logic [63:0] got_v);
        $display("%0t mismatch %s: expected %0h got %0h", $time, what, exp_v, got_v);
        mismatch_count++;
    endtask

    task automatic predict_lease_reply(input in_item_t it, output bit produces,
                                       output out_item_t rep);
        int          hit;
        int          slot;
        logic [31:0] addr;
        logic        full;
        hit      = -1;
        slot     = -1;
        full     = 1'b0;
        addr     = '0;
        produces = 1'b1;
        for (int i = 0; i < LEASE_ENTRIES; i++)
        begin
            if (hit < 0 && lease_used[i] && lease_mac_tab[i] == it.client_mac)
                hit = i;
            if (slot < 0 && !lease_used[i])
                slot = i;
        end
        if (it.mode == MODE_DISCOVER)
        begin
            if (hit >= 0)
                addr = lease_ip_tab[hit];
            else if (pool_left == 0 || slot < 0)
                produces = 1'b0;
            else
            begin
                addr = net_base + 32'(POOL_FIRST + pool_left - 1);
                pool_left--;
                lease_used[slot]    = 1'b1;
                lease_mac_tab[slot] = it.client_mac;
                lease_ip_tab[slot]  = addr;
            end
        end
        else
        begin
            addr = it.requested_ip;
            if (hit >= 0)
                lease_ip_tab[hit] = addr;
            else if (slot < 0)
                full = 1'b1;
            else
            begin
                lease_used[slot]    = 1'b1;
                lease_mac_tab[slot] = it.client_mac;
                lease_ip_tab[slot]  = addr;
            end
        end
        rep.reply_kind = (it.mode == MODE_REQUEST) ? REPLY_ACK : REPLY_OFFER;
        rep.reply_ip   = addr;
        rep.dest_ip    = (it.source_ip != '0) ? it.source_ip : BCAST_IP;
        rep.dest_port  = (it.source_ip != '0) ? it.source_port : BCAST_PORT;
        rep.table_full = full;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bit        produces;
        out_item_t rep;
        out_item_t want;
        if (!rst_n)
        begin
            net_base       = '0;
            pool_left      = (POOL_END > POOL_FIRST) ? POOL_END - POOL_FIRST : 0;
            mismatch_count = 0;
            for (int i = 0; i < LEASE_ENTRIES; i++)
                lease_used[i] = 1'b0;
            expected_replies.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                net_base = cfg_data;
            if (req_valid && !req_stall)
            begin
                predict_lease_reply(req_item, produces, rep);
                if (produces)
                    expected_replies = {expected_replies, rep};
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_replies.size() == 0)
                    report("unexpected reply", '0, 64'(rsp_item.reply_ip));
                else
                begin
                    want = expected_replies.pop_front();
                    if (rsp_item.reply_kind !== want.reply_kind)
                        report("reply_kind", 64'(want.reply_kind),
                               64'(rsp_item.reply_kind));
                    if (rsp_item.reply_ip !== want.reply_ip)
                        report("reply_ip", 64'(want.reply_ip), 64'(rsp_item.reply_ip));
                    if (rsp_item.dest_ip !== want.dest_ip)
                        report("dest_ip", 64'(want.dest_ip), 64'(rsp_item.dest_ip));
                    if (rsp_item.dest_port !== want.dest_port)
                        report("dest_port", 64'(want.dest_port), 64'(rsp_item.dest_port));
                    if (rsp_item.table_full !== want.table_full)
                        report("table_full", 64'(want.table_full),
                               64'(rsp_item.table_full));
                end
            end
            outstanding <= expected_replies.size();
        end
    end

endmodule

### test/dhcp_lease_allocator_top_tb.sv
`timescale 1ns / 1ps
// dhcp_lease_allocator_top_tb: drives discover and request items and base register
// writes into the lease allocator, with random gaps and reply stalls
// depends on dla_pkg, dhcp_lease_allocator_top and dla_lease_checker
module dhcp_lease_allocator_top_tb;
    import dla_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    in_item_t    req_item;
    logic        rsp_valid;
    logic        rsp_stall;
    out_item_t   rsp_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    int          mismatch_count;
    int          outstanding;
    logic [47:0] mac_book [96];

    dhcp_lease_allocator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    dla_lease_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_item       (req_item),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_item       (rsp_item),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
        clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // reply stalls: short bursts, long holds and stall-free stretches
    initial
    begin
        int  pick;
        int  len;
        bit  level;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                level = 1'b0;
                len   = $urandom_range(1, 8);
            end
            else if (pick < 85)
            begin
                level = 1'b1;
                len   = $urandom_range(1, 3);
            end
            else if (pick < 95)
            begin
                level = 1'b0;
                len   = $urandom_range(20, 60);
            end
            else
            begin
                level = 1'b1;
                len   = $urandom_range(20, 80);
            end
            repeat (len) @(negedge clk) rsp_stall <= level;
        end
    end

    function automatic int pick_gap(input bit burst);
        int pick;
        pick = $urandom_range(0, 99);
        if (burst || pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 100);
    endfunction

    function automatic in_item_t build_item(input logic mode, input logic [47:0] mac,
                                            input logic [31:0] req_ip,
                                            input logic [31:0] src_ip,
                                            input logic [15:0] src_port);
        in_item_t it;
        it.mode         = mode;
        it.client_mac   = mac;
        it.requested_ip = req_ip;
        it.source_ip    = src_ip;
        it.source_port  = src_port;
        return it;
    endfunction

    // known macs come from a range that widens as the run goes on, so the table fills gradually
    function automatic in_item_t random_item(input int issued);
        in_item_t it;
        int       pick;
        int       span;
        span = (issued / 3 + 6 > 95) ? 95 : issued / 3 + 6;
        it.mode = $urandom_range(0, 1) ? MODE_REQUEST : MODE_DISCOVER;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            it.client_mac = mac_book[$urandom_range(0, span)];
        else
            it.client_mac = 48'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        it.requested_ip = (pick < 10) ? 32'h0 : (pick < 20) ? 32'hFFFF_FFFF : $urandom;
        pick = $urandom_range(0, 99);
        it.source_ip = (pick < 25) ? 32'h0 : (pick < 30) ? 32'hFFFF_FFFF : $urandom;
        it.source_port = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    task automatic push_request(input in_item_t it, input int gap);
        repeat (gap) @(negedge clk) req_valid <= 1'b0;
        @(negedge clk);
        req_valid <= 1'b1;
        req_item  <= it;
        do @(posedge clk); while (req_stall);
    endtask

    // a dropped discover may still be in the search, hence the extra cycles
    task automatic write_base_when_idle(input logic [31:0] value);
        @(negedge clk) req_valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] bases [5];
        int          issued;
        int          waited;
        bit          burst;
        req_valid = 1'b0;
        req_item  = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        mac_book[0] = '0;
        mac_book[1] = '1;
        for (int i = 2; i < 96; i++)
        begin
            if (i % 4 == 3)
                mac_book[i] = mac_book[i - 1] ^ (48'h1 << $urandom_range(0, 47));
            else
                mac_book[i] = 48'({$urandom, $urandom});
        end
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        write_base_when_idle(32'h0000_0000);
        push_request(build_item(MODE_DISCOVER, mac_book[2], 32'h1234_5678, 32'h0, 16'h1234),
                     pick_gap(1'b0));
        push_request(build_item(MODE_DISCOVER, mac_book[2], 32'h0, 32'hFFFF_FFFF, 16'hFFFF),
                     pick_gap(1'b0));
        push_request(build_item(MODE_REQUEST, mac_book[4], 32'hFFFF_FFFF, 32'h1, 16'h0),
                     pick_gap(1'b0));
        push_request(build_item(MODE_DISCOVER, mac_book[4], 32'h0, 32'h0, 16'hFFFF),
                     pick_gap(1'b0));
        push_request(build_item(MODE_REQUEST, mac_book[2], 32'h0, 32'h0, 16'h0),
                     pick_gap(1'b0));
        push_request(build_item(MODE_DISCOVER, mac_book[2], 32'hFFFF_FFFF, 32'hC0A8_0001,
                                16'd67), pick_gap(1'b0));
        push_request(build_item(MODE_DISCOVER, mac_book[0], 32'h0, 32'h0, 16'h0),
                     pick_gap(1'b0));
        push_request(build_item(MODE_DISCOVER, mac_book[1], 32'hFFFF_FFFF, 32'h8000_0000,
                                16'h8000), pick_gap(1'b0));
        push_request(build_item(MODE_REQUEST, mac_book[1], 32'h0A00_0001, 32'hC0A8_0001,
                                16'd67), pick_gap(1'b0));
        push_request(build_item(MODE_DISCOVER, mac_book[3], 32'h0, 32'h0, 16'h0),
                     pick_gap(1'b0));
        push_request(build_item(MODE_REQUEST, mac_book[0], 32'h8000_0001, 32'h0, 16'hFFFF),
                     pick_gap(1'b0));

        // base wraps past the top of the address space
        write_base_when_idle(32'hFFFF_FFFF);
        push_request(build_item(MODE_DISCOVER, mac_book[5], 32'h0, 32'h0, 16'h0),
                     pick_gap(1'b0));
        push_request(build_item(MODE_DISCOVER, mac_book[2], 32'h0, 32'h7FFF_FFFF, 16'h7FFF),
                     pick_gap(1'b0));
        push_request(build_item(MODE_DISCOVER, mac_book[6], 32'h0, 32'h1, 16'h1),
                     pick_gap(1'b0));
        push_request(build_item(MODE_REQUEST, mac_book[7], 32'h5555_5555, 32'hAAAA_AAAA,
                                16'h5555), pick_gap(1'b0));
        push_request(build_item(MODE_DISCOVER, mac_book[7], 32'hAAAA_AAAA, 32'h0, 16'hAAAA),
                     pick_gap(1'b0));

        bases[0] = 32'hC0A8_0100;
        bases[1] = $urandom;
        bases[2] = 32'hFFFF_FF9C;
        bases[3] = 32'h0000_0000;
        bases[4] = $urandom;
        issued = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_base_when_idle(bases[phase]);
            burst = 1'b0;
            for (int n = 0; n < 150; n++)
            begin
                if (n % 50 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                push_request(random_item(issued), pick_gap(burst));
                issued++;
            end
        end

        @(negedge clk) req_valid <= 1'b0;
        waited = 0;
        while (outstanding != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
